// File: rtl/pss_pkg.sv
// ---------------------------------------------------------------------------
// pss_pkg
// Shared types and codes for the periodic send scheduler.
// ---------------------------------------------------------------------------
package pss_pkg;

    localparam logic [1:0] ACT_CLEAR    = 2'd0;
    localparam logic [1:0] ACT_REGISTER = 2'd1;
    localparam logic [1:0] ACT_DISPATCH = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int CountW = 7;
    localparam logic [CountW-1:0] MaxCount = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_UPDATE,
        S_DONE
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic clear;
        logic reg_wr;
        logic scan_start;
        logic scan_step;
        logic update;
        logic emit_pick;
        logic emit_misc;
        logic [1:0] status;
        logic last;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic scan_end;
    } t_stat;

endpackage

// File: rtl/pss_datapath.sv
// ---------------------------------------------------------------------------
// pss_datapath
// User table memory, serial minimum scan and due-time update.
// ---------------------------------------------------------------------------
module pss_datapath
    import pss_pkg::*;
#(
    parameter int MAX_USERS = 64,
    parameter int TIME_BITS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [15:0] i_user_id,
    input  logic [15:0] i_period,
    output t_stat       o_stat,
    output logic [15:0] o_sent_id,
    output logic [1:0]  o_status,
    output logic        o_last,
    output logic        o_valid
);
    localparam int IdxW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int OccW = $clog2(MAX_USERS + 1);
    localparam int EntW = 32 + TIME_BITS;
    localparam logic [TIME_BITS-1:0] TimeMax = '1;

    // entry = {user, period, due}
    logic [EntW-1:0] mem [MAX_USERS];
    logic [EntW-1:0] r_rd;
    logic [IdxW-1:0] r_rd_idx;
    logic [OccW-1:0] r_occ;
    logic [OccW-1:0] r_ptr;
    logic [IdxW-1:0] r_best;
    logic [15:0]     r_best_user;
    logic [15:0]     r_best_per;
    logic [TIME_BITS-1:0] r_best_due;
    logic            r_have;

    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [EntW-1:0] wr_data;
    logic [15:0]     rd_user;
    logic [15:0]     rd_per;
    logic [TIME_BITS-1:0] rd_due;
    logic            better;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] new_due;

    assign rd_addr = r_ptr[IdxW-1:0];
    assign rd_user = r_rd[EntW-1 -: 16];
    assign rd_per  = r_rd[TIME_BITS +: 16];
    assign rd_due  = r_rd[TIME_BITS-1:0];
    assign better  = !r_have || (rd_due < r_best_due) ||
                     ((rd_due == r_best_due) && (rd_user < r_best_user));

    assign sum     = {1'b0, r_best_due} + {{(TIME_BITS-15){1'b0}}, r_best_per};
    assign new_due = sum[TIME_BITS] ? TimeMax : sum[TIME_BITS-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_best;
        wr_data = {r_best_user, r_best_per, new_due};
        if (i_cmd.reg_wr && (r_occ < OccW'(MAX_USERS))) begin
            wr_en   = 1'b1;
            wr_addr = r_occ[IdxW-1:0];
            wr_data = {i_user_id, i_period, {(TIME_BITS-16){1'b0}}, i_period};
        end else if (i_cmd.update) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd     <= mem[rd_addr];
        r_rd_idx <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_ptr   <= '0;
            r_have  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit_pick || i_cmd.emit_misc;
            if (i_cmd.clear) begin
                r_occ <= '0;
            end else if (i_cmd.reg_wr && (r_occ < OccW'(MAX_USERS))) begin
                r_occ <= r_occ + 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_ptr  <= '0;
                r_have <= 1'b0;
            end else if (i_cmd.scan_step) begin
                // entry at r_ptr is read on this edge; compare the previous one
                r_ptr <= r_ptr + 1'b1;
                r_have <= 1'b1;
            end
        end
    end

    // best-so-far compare uses r_rd from the prior read
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && better) begin
            r_best      <= r_rd_idx;
            r_best_user <= rd_user;
            r_best_per  <= rd_per;
            r_best_due  <= rd_due;
        end
        if (i_cmd.emit_pick) begin
            o_sent_id <= r_best_user;
            o_status  <= ST_OK;
            o_last    <= i_cmd.last;
        end else if (i_cmd.emit_misc) begin
            o_sent_id <= '0;
            o_status  <= i_cmd.status;
            o_last    <= 1'b1;
        end
    end

    assign o_stat.full     = (r_occ >= OccW'(MAX_USERS));
    assign o_stat.empty    = (r_occ == '0);
    assign o_stat.scan_end = (r_ptr >= r_occ);
endmodule

// File: rtl/pss_ctrl.sv
// ---------------------------------------------------------------------------
// pss_ctrl
// Command sequencer: decodes actions, walks dispatch sends.
// ---------------------------------------------------------------------------
module pss_ctrl
    import pss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [1:0]  i_action,
    input  logic [CountW-1:0] i_count,
    input  t_stat       i_stat,
    output logic        busy,
    output t_cmd        o_cmd
);
    t_state r_state, n_state;
    logic [CountW-1:0] r_left, n_left;
    logic accept;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_action == ACT_DISPATCH) && !i_stat.empty &&
                    (i_count != '0)) begin
                    n_state = S_SCAN_RD;
                    n_left  = (i_count > MaxCount) ? MaxCount : i_count;
                end
            end
            S_SCAN_RD: n_state = S_SCAN;
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_left  = r_left - 1'b1;
                n_state = (r_left == CountW'(1)) ? S_DONE : S_SCAN_RD;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.clear  = (i_action == ACT_CLEAR);
                    o_cmd.reg_wr = (i_action == ACT_REGISTER);
                    o_cmd.scan_start = 1'b1;
                    if (i_action == ACT_REGISTER) begin
                        o_cmd.emit_misc = 1'b1;
                        o_cmd.status = i_stat.full ? ST_FULL : ST_OK;
                    end else if (i_action == ACT_DISPATCH) begin
                        o_cmd.emit_misc = i_stat.empty;
                        o_cmd.status    = ST_EMPTY;
                    end else begin
                        o_cmd.emit_misc = 1'b1;
                        o_cmd.status    = ST_OK;
                    end
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_step = 1'b0;
            end
            S_SCAN: begin
                // step compares the entry read last cycle and reads the next
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_end) begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_UPDATE: begin
                o_cmd.update     = 1'b1;
                o_cmd.emit_pick  = 1'b1;
                o_cmd.last       = (r_left == CountW'(1));
                o_cmd.scan_start = 1'b1;
            end
            S_DONE: o_cmd = '0;
            default: o_cmd = '0;
        endcase
    end
endmodule

// File: rtl/periodic_send_scheduler.sv
// ---------------------------------------------------------------------------
// periodic_send_scheduler
// Table of periodic users; dispatch serves earliest due time, ties by id.
// ---------------------------------------------------------------------------
//  channel   ports                                   handshake
//  command   i_action i_user_id i_period i_count     start & !busy
//  result    o_sent_id o_status o_last               o_valid, one cycle
//
// Clear, register and other actions are accepted while idle and give
// a registered result in the next cycle. A dispatch send scans the
// table serially through one memory read port, one result per send.
// Reset (synchronous, active low) empties the table. The result
// side cannot stall; results are strobed once.
// ---------------------------------------------------------------------------
module periodic_send_scheduler
    import pss_pkg::*;
#(
    parameter int MAX_USERS = 64,
    parameter int TIME_BITS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_user_id,
    input  logic [15:0] i_period,
    input  logic [6:0]  i_count,
    output logic        o_valid,
    output logic [15:0] o_sent_id,
    output logic [1:0]  o_status,
    output logic        o_last
);
    t_cmd  cmd;
    t_stat stat;

    pss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_count  (i_count),
        .i_stat   (stat),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    pss_datapath #(
        .MAX_USERS (MAX_USERS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_user_id (i_user_id),
        .i_period  (i_period),
        .o_stat    (stat),
        .o_sent_id (o_sent_id),
        .o_status  (o_status),
        .o_last    (o_last),
        .o_valid   (o_valid)
    );
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for periodic_send_scheduler. Commands go in through
// start/busy; every strobed result is matched against a scoreboard filled
// by an in-bench table model (earliest due time first, ties by lower id).
// ---------------------------------------------------------------------------
module tb_top;
    import pss_pkg::*;

    localparam int         NUM_USERS  = 64;
    localparam int         DUE_W      = 40;
    localparam logic [1:0] ACT_UNUSED = 2'd3;          // spare action code
    localparam longint     CYCLE_CAP  = 10_000_000;    // hard stop
    localparam int         RAND_ITEMS = 350;

    typedef struct {
        logic [15:0] sent_id;
        logic [1:0]  status;
        logic        last;
    } t_send_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_action = '0;
    logic [15:0] i_user_id = '0;
    logic [15:0] i_period = '0;
    logic [6:0]  i_count = '0;
    logic        o_valid;
    logic [15:0] o_sent_id;
    logic [1:0]  o_status;
    logic        o_last;

    periodic_send_scheduler #(.MAX_USERS(NUM_USERS), .TIME_BITS(DUE_W)) dut (.*);

    always #10 i_clk = ~i_clk;

    // bench copy of the user table
    logic [15:0]      tbl_user [NUM_USERS];
    logic [15:0]      tbl_period [NUM_USERS];
    logic [DUE_W-1:0] tbl_due [NUM_USERS];
    int               tbl_fill = 0;

    t_send_res expected_sends [$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        burst_left = 0;
    longint    cycles = 0;

    // ------------------------------------------------------------------
    // Scheduling model: turns one accepted command into its results.
    // ------------------------------------------------------------------
    task automatic push_res(logic [15:0] id, logic [1:0] st, logic lst);
        t_send_res r;
        r.sent_id = id;
        r.status  = st;
        r.last    = lst;
        expected_sends.push_back(r);
    endtask

    task automatic schedule_model(logic [1:0] act, logic [15:0] uid,
                                  logic [15:0] per, logic [6:0] cnt);
        int          n;
        int          best;
        logic [DUE_W:0] sum;
        if (act == ACT_CLEAR) begin
            tbl_fill = 0;
            push_res('0, ST_OK, 1'b1);
        end else if (act == ACT_REGISTER) begin
            if (tbl_fill >= NUM_USERS) begin
                push_res('0, ST_FULL, 1'b1);
            end else begin
                tbl_user[tbl_fill]   = uid;
                tbl_period[tbl_fill] = per;
                tbl_due[tbl_fill]    = DUE_W'(per);
                tbl_fill++;
                push_res('0, ST_OK, 1'b1);
            end
        end else if (act == ACT_DISPATCH) begin
            if (tbl_fill == 0) begin
                push_res('0, ST_EMPTY, 1'b1);
            end else begin
                n = (cnt > MaxCount) ? int'(MaxCount) : int'(cnt);
                for (int k = 0; k < n; k++) begin
                    best = 0;
                    for (int i = 1; i < tbl_fill; i++)
                        if (tbl_due[i] < tbl_due[best] ||
                            (tbl_due[i] == tbl_due[best] && tbl_user[i] < tbl_user[best]))
                            best = i;
                    push_res(tbl_user[best], ST_OK, k == n - 1);
                    // due time saturates at all ones
                    sum = {1'b0, tbl_due[best]} + tbl_period[best];
                    tbl_due[best] = sum[DUE_W] ? '1 : sum[DUE_W-1:0];
                end
            end
        end else begin
            push_res('0, ST_OK, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Command driver: bursts with random gaps; start stays high across
    // back-to-back beats and drops only inside a gap or in go_idle.
    // ------------------------------------------------------------------
    task automatic send_cmd(logic [1:0] act, logic [15:0] uid,
                            logic [15:0] per, logic [6:0] cnt);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                start = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        start     = 1'b1;
        i_action  = act;
        i_user_id = uid;
        i_period  = per;
        i_count   = cnt;
        do @(posedge i_clk); while (busy);
        schedule_model(act, uid, per, cnt);
        items_sent++;
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // hold off until the scoreboard is empty
    task automatic drain();
        go_idle();
        while (expected_sends.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker: one beat per strobe, no back-pressure possible.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_send_res exp_r;
        if (i_rst_n && o_valid) begin
            if (expected_sends.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: id=%0d st=%0d last=%0d",
                             o_sent_id, o_status, o_last);
            end else begin
                exp_r = expected_sends.pop_front();
                if (o_sent_id !== exp_r.sent_id || o_status !== exp_r.status ||
                    o_last !== exp_r.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp id=%0d st=%0d last=%0d,",
                                  " got id=%0d st=%0d last=%0d"},
                                 exp_r.sent_id, exp_r.status, exp_r.last,
                                 o_sent_id, o_status, o_last);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // corner commands: empty dispatch, spare action, count 0 and oversize
    task automatic test_basic();
        send_cmd(ACT_DISPATCH, '0, '0, 7'd5);          // empty table
        send_cmd(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 7'h7F);
        send_cmd(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 7'h7F);
        send_cmd(ACT_REGISTER, 16'hFFFF, 16'hFFFF, '0);
        send_cmd(ACT_REGISTER, 16'h0000, 16'h0001, '0);
        send_cmd(ACT_REGISTER, 16'h1234, 16'h0000, '0); // zero period never advances
        send_cmd(ACT_DISPATCH, '0, '0, 7'd0);          // no result
        send_cmd(ACT_DISPATCH, '0, '0, 7'd3);
        send_cmd(ACT_DISPATCH, '0, '0, 7'h7F);         // clamps to 64
        send_cmd(ACT_CLEAR, '0, '0, '0);
        send_cmd(ACT_DISPATCH, '0, '0, 7'd1);
    endtask

    // equal due times: lower id wins; same id: lower slot wins
    task automatic test_ties();
        send_cmd(ACT_CLEAR, '0, '0, '0);
        send_cmd(ACT_REGISTER, 16'd9, 16'd4, '0);
        send_cmd(ACT_REGISTER, 16'd3, 16'd4, '0);
        send_cmd(ACT_REGISTER, 16'd3, 16'd2, '0);
        send_cmd(ACT_REGISTER, 16'd7, 16'd4, '0);
        send_cmd(ACT_DISPATCH, '0, '0, 7'd12);
    endtask

    // fill to capacity, overflow, full-size dispatch
    task automatic test_full();
        send_cmd(ACT_CLEAR, '0, '0, '0);
        for (int i = 0; i < NUM_USERS; i++)
            send_cmd(ACT_REGISTER, 16'($urandom), 16'($urandom_range(1, 40)), '0);
        send_cmd(ACT_REGISTER, 16'hAAAA, 16'h5555, '0);   // table full
        send_cmd(ACT_DISPATCH, '0, '0, 7'd64);
        drain();
    endtask

    // random: mostly clear/register/dispatch sequences, some noise
    task automatic test_random();
        int          n_reg;
        logic [15:0] uid;
        logic [15:0] per;
        while (items_sent < RAND_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: send_cmd(ACT_UNUSED, 16'($urandom), 16'($urandom), 7'($urandom));
                    1: send_cmd(ACT_DISPATCH, 16'($urandom), 16'($urandom), 7'd0);
                    2: send_cmd(ACT_CLEAR, 16'($urandom), 16'($urandom), 7'($urandom));
                    default: send_cmd(ACT_REGISTER, 16'($urandom), 16'($urandom), '0);
                endcase
            end else begin
                if ($urandom_range(0, 2) != 0)
                    send_cmd(ACT_CLEAR, '0, '0, '0);
                n_reg = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 66)
                                                     : $urandom_range(1, 10);
                for (int i = 0; i < n_reg; i++) begin
                    // small id/period pools to force ties
                    uid = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7))
                                                      : 16'($urandom);
                    case ($urandom_range(0, 5))
                        0: per = 16'($urandom);
                        1: per = 16'd0;
                        default: per = 16'($urandom_range(1, 8));
                    endcase
                    send_cmd(ACT_REGISTER, uid, per, 7'($urandom));
                end
                repeat ($urandom_range(1, 4))
                    send_cmd(ACT_DISPATCH, 16'($urandom), 16'($urandom),
                             ($urandom_range(0, 19) == 0) ? 7'($urandom)
                                                          : 7'($urandom_range(1, 10)));
            end
            if ($urandom_range(0, 29) == 0)
                drain();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_basic();
        test_ties();
        test_full();
        test_random();
        drain();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && expected_sends.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
